// ===== hdl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int DEF_MAX_PAGES = 32768;
  localparam int DEF_TOP_RANK  = 16;

  localparam int PAGE_W = 16;
  localparam int RANK_W = 5;

  localparam logic [PAGE_W-1:0] NIL = 16'hFFFF;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QRANK = 2'd2;
  localparam logic [1:0] OP_QCNT  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // write mask bits of the page store
  localparam int MB_META = 2;
  localparam int MB_NEXT = 1;
  localparam int MB_PREV = 0;

  localparam logic [2:0] WM_ALL  = 3'b111;
  localparam logic [2:0] WM_META = 3'b100;
  localparam logic [2:0] WM_NEXT = 3'b010;
  localparam logic [2:0] WM_PREV = 3'b001;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              free;
    logic [PAGE_W-1:0] next;
    logic [PAGE_W-1:0] prev;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [2:0]        mask;
    logic [PAGE_W-1:0] addr;
    entry_t            data;
  } mem_req_t;

  // largest aligned rank that fits at idx below pool, capped at top
  function automatic logic [RANK_W-1:0] fit_rank(input logic [PAGE_W-1:0] idx,
                                                 input logic [PAGE_W-1:0] pool,
                                                 input logic [RANK_W-1:0] top);
    logic [PAGE_W-1:0] rem;
    logic [RANK_W-1:0] tz;
    logic [RANK_W-1:0] lg;
    logic [RANK_W-1:0] k;
    rem = pool - idx;
    tz  = RANK_W'(PAGE_W);
    for (int i = PAGE_W - 1; i >= 0; i--) begin
      if (idx[i]) tz = RANK_W'(i);
    end
    lg = '0;
    for (int i = 0; i < PAGE_W; i++) begin
      if (rem[i]) lg = RANK_W'(i);
    end
    k = tz;
    if (lg < k) k = lg;
    if (top - 5'd1 < k) k = top - 5'd1;
    return k + 5'd1;
  endfunction

endpackage

// ===== hdl/bpa_page_store.sv =====
// ----------------------------------------------------------------------------
// bpa_page_store
// Per-page state memory: rank, free flag and list links, with field write
// masks and a registered read.
// ----------------------------------------------------------------------------
module bpa_page_store import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  localparam int AW = $clog2(MAX_PAGES);

  entry_t          mem [MAX_PAGES];
  logic [AW-1:0]   a;

  assign a = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      if (req.mask[MB_META]) begin
        mem[a].rank <= req.data.rank;
        mem[a].free <= req.data.free;
      end
      if (req.mask[MB_NEXT]) mem[a].next <= req.data.next;
      if (req.mask[MB_PREV]) mem[a].prev <= req.data.prev;
    end else begin
      rdata <= mem[a];
    end
  end

endmodule

// ===== hdl/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over page indices with per-rank doubly linked free lists.
// ----------------------------------------------------------------------------
// One request word is taken at a time and gives one result word. All
// per-page state sits in a single-port page memory, so timing is set by the
// number of accesses to it. Allocate searches the free lists upward from the
// requested rank, unlinks the block it finds, splits it down to the requested
// rank and finishes. Free merges the block with its free buddy rank by rank.
// Queries read one page entry or one list count, and a rejected word goes
// straight to the result. Each result may also wait on out_ready. After reset
// and after each non-zero pool size write the block clears the page memory and
// then pushes each initial free block onto its list; no request is taken meanwhile.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int TOP_RANK  = DEF_TOP_RANK
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [4:0]  req_rank,
  input  logic [15:0] page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [14:0] alloc_page,
  output logic [15:0] value
);

  localparam int AW = $clog2(MAX_PAGES);
  localparam int HW = $clog2(TOP_RANK);
  localparam logic [RANK_W-1:0] TOP = RANK_W'(TOP_RANK);
  localparam logic [PAGE_W-1:0] MAXP = PAGE_W'(MAX_PAGES);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_BLD    = 5'd2;
  localparam logic [4:0] S_PUSH_A = 5'd3;
  localparam logic [4:0] S_PUSH_B = 5'd4;
  localparam logic [4:0] S_SRCH   = 5'd5;
  localparam logic [4:0] S_UL_RD  = 5'd6;
  localparam logic [4:0] S_UL_CHK = 5'd7;
  localparam logic [4:0] S_UL_N   = 5'd8;
  localparam logic [4:0] S_UL_P   = 5'd9;
  localparam logic [4:0] S_UL_F   = 5'd10;
  localparam logic [4:0] S_SPL    = 5'd11;
  localparam logic [4:0] S_AL_FIN = 5'd12;
  localparam logic [4:0] S_FR_RD  = 5'd13;
  localparam logic [4:0] S_FR_CHK = 5'd14;
  localparam logic [4:0] S_MG     = 5'd15;
  localparam logic [4:0] S_MG_CHK = 5'd16;
  localparam logic [4:0] S_MG_W   = 5'd17;
  localparam logic [4:0] S_Q_RD   = 5'd18;
  localparam logic [4:0] S_Q_CHK  = 5'd19;
  localparam logic [4:0] S_CNT    = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;

  logic [4:0]        state;
  logic [PAGE_W-1:0] pool;
  logic [AW-1:0]     cnt;
  logic              bld;
  logic [1:0]        op_r;
  logic [RANK_W-1:0] rr;
  logic [PAGE_W-1:0] pg;
  logic [PAGE_W-1:0] idx;
  logic [PAGE_W-1:0] pidx;
  logic [PAGE_W-1:0] uidx;
  logic [PAGE_W-1:0] bud;
  logic [PAGE_W-1:0] oldh;
  logic [RANK_W-1:0] rk;
  entry_t            ent;
  logic [1:0]        res_status;
  logic [14:0]       res_apage;
  logic [15:0]       res_value;

  logic [PAGE_W-1:0] heads  [TOP_RANK];
  logic [PAGE_W-1:0] counts [TOP_RANK];

  logic [HW-1:0]     hidx;
  logic [PAGE_W-1:0] head_rk;
  logic [PAGE_W-1:0] cnt_rk;
  logic              rk_ok;
  logic              cfg_go;
  logic [PAGE_W-1:0] cfg_pool;
  logic [RANK_W-1:0] fr_bld;
  logic [PAGE_W-1:0] bud_c;
  logic              in_rank_ok;
  logic              head_we;
  logic [PAGE_W-1:0] head_wd;
  logic              cnt_inc;
  logic              cnt_dec;
  mem_req_t          mreq;
  entry_t            rdata;

  assign hidx    = HW'(rk - 5'd1);
  assign head_rk = heads[hidx];
  assign cnt_rk  = counts[hidx];
  assign rk_ok   = (rk >= 5'd1) && (rk <= TOP);
  assign in_rank_ok = (req_rank >= 5'd1) && (req_rank <= TOP);

  assign cfg_go   = wr_en && (wr_data != 16'd0);
  assign cfg_pool = (wr_data > MAXP) ? MAXP : wr_data;
  assign fr_bld   = fit_rank(idx, pool, TOP);
  assign bud_c    = idx ^ (16'd1 << (rk - 5'd1));

  assign in_ready = (state == S_IDLE);

  bpa_page_store #(.MAX_PAGES(MAX_PAGES)) u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // page memory requests
  always_comb begin
    mreq      = '0;
    mreq.addr = pg;
    mreq.data = '0;
    unique case (state)
      S_CLR: begin
        mreq.we        = 1'b1;
        mreq.mask      = WM_ALL;
        mreq.addr      = PAGE_W'(cnt);
        mreq.data.next = NIL;
        mreq.data.prev = NIL;
      end
      S_PUSH_A: begin
        mreq.we        = 1'b1;
        mreq.mask      = WM_ALL;
        mreq.addr      = pidx;
        mreq.data.rank = rk;
        mreq.data.free = 1'b1;
        mreq.data.next = head_rk;
        mreq.data.prev = NIL;
      end
      S_PUSH_B: begin
        mreq.we        = (oldh != NIL);
        mreq.mask      = WM_PREV;
        mreq.addr      = oldh;
        mreq.data.prev = pidx;
      end
      S_UL_RD: mreq.addr = uidx;
      S_UL_N: begin
        mreq.we        = (ent.next != NIL);
        mreq.mask      = WM_PREV;
        mreq.addr      = ent.next;
        mreq.data.prev = ent.prev;
      end
      S_UL_P: begin
        mreq.we        = (ent.prev != NIL);
        mreq.mask      = WM_NEXT;
        mreq.addr      = ent.prev;
        mreq.data.next = ent.next;
      end
      S_UL_F: begin
        mreq.we        = 1'b1;
        mreq.mask      = WM_META;
        mreq.addr      = uidx;
        mreq.data.rank = (op_r == OP_ALLOC) ? ent.rank : 5'd0;
      end
      S_AL_FIN: begin
        mreq.we        = 1'b1;
        mreq.mask      = WM_META;
        mreq.addr      = idx;
        mreq.data.rank = rr;
      end
      S_MG: mreq.addr = bud_c;
      S_MG_W: begin
        mreq.we   = 1'b1;
        mreq.mask = WM_META;
        mreq.addr = idx;
      end
      default: mreq.addr = pg;
    endcase
  end

  // free list heads and counts
  always_comb begin
    head_we = 1'b0;
    head_wd = pidx;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    if (state == S_PUSH_A) begin
      head_we = 1'b1;
      cnt_inc = 1'b1;
    end else if (state == S_UL_P && rk_ok) begin
      head_we = (ent.prev == NIL);
      head_wd = ent.next;
      cnt_dec = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_go) begin
      for (int i = 0; i < TOP_RANK; i++) begin
        heads[i]  <= NIL;
        counts[i] <= '0;
      end
    end else begin
      if (head_we) heads[hidx] <= head_wd;
      if (cnt_inc) counts[hidx] <= cnt_rk + 16'd1;
      else if (cnt_dec) counts[hidx] <= cnt_rk - 16'd1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      pool      <= MAXP;
      cnt       <= '0;
      bld       <= 1'b1;
      out_valid <= 1'b0;
    end else if (cfg_go) begin
      state <= S_CLR;
      pool  <= cfg_pool;
      cnt   <= '0;
      bld   <= 1'b1;
    end else begin
      // the finish state owns out_valid while it is active
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            rr         <= req_rank;
            pg         <= page;
            rk         <= req_rank;
            res_status <= ST_OK;
            res_apage  <= '0;
            res_value  <= '0;
            unique case (op)
              OP_ALLOC: begin
                if (in_rank_ok) state <= S_SRCH;
                else begin
                  res_status <= ST_INVAL;
                  state      <= S_FIN;
                end
              end
              OP_FREE: begin
                if (page < pool) state <= S_FR_RD;
                else begin
                  res_status <= ST_INVAL;
                  state      <= S_FIN;
                end
              end
              OP_QRANK: begin
                if (page < pool) state <= S_Q_RD;
                else begin
                  res_status <= ST_INVAL;
                  state      <= S_FIN;
                end
              end
              OP_QCNT: begin
                if (in_rank_ok) state <= S_CNT;
                else begin
                  res_status <= ST_INVAL;
                  state      <= S_FIN;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(MAX_PAGES - 1)) begin
            idx   <= '0;
            state <= S_BLD;
          end
        end
        S_BLD: begin
          if (idx < pool) begin
            rk    <= fr_bld;
            pidx  <= idx;
            idx   <= idx + (16'd1 << (fr_bld - 5'd1));
            state <= S_PUSH_A;
          end else begin
            bld   <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_PUSH_A: begin
          oldh  <= head_rk;
          state <= S_PUSH_B;
        end
        S_PUSH_B: begin
          if (bld) state <= S_BLD;
          else if (op_r == OP_ALLOC) state <= S_SPL;
          else state <= S_FIN;
        end
        S_SRCH: begin
          if (head_rk != NIL) begin
            uidx  <= head_rk;
            idx   <= head_rk;
            state <= S_UL_RD;
          end else if (rk == TOP) begin
            res_status <= ST_NOSPACE;
            state      <= S_FIN;
          end else begin
            rk <= rk + 5'd1;
          end
        end
        S_UL_RD:  state <= S_UL_CHK;
        S_UL_CHK: begin
          ent   <= rdata;
          state <= S_UL_N;
        end
        S_UL_N: state <= S_UL_P;
        S_UL_P: state <= S_UL_F;
        S_UL_F: state <= (op_r == OP_ALLOC) ? S_SPL : S_MG_W;
        S_SPL: begin
          if (rk == rr) state <= S_AL_FIN;
          else begin
            rk    <= rk - 5'd1;
            pidx  <= idx ^ (16'd1 << (rk - 5'd2));
            state <= S_PUSH_A;
          end
        end
        S_AL_FIN: begin
          res_apage <= idx[14:0];
          state     <= S_FIN;
        end
        S_FR_RD: state <= S_FR_CHK;
        S_FR_CHK: begin
          if (rdata.rank < 5'd1 || rdata.rank > TOP || rdata.free) begin
            res_status <= ST_INVAL;
            state      <= S_FIN;
          end else begin
            idx   <= pg;
            rk    <= rdata.rank;
            state <= S_MG;
          end
        end
        S_MG: begin
          if (rk < TOP && bud_c < pool) begin
            bud   <= bud_c;
            state <= S_MG_CHK;
          end else begin
            pidx  <= idx;
            state <= S_PUSH_A;
          end
        end
        S_MG_CHK: begin
          if (!rdata.free || rdata.rank != rk) begin
            pidx  <= idx;
            state <= S_PUSH_A;
          end else begin
            ent   <= rdata;
            uidx  <= bud;
            state <= S_UL_N;
          end
        end
        S_MG_W: begin
          if (bud < idx) idx <= bud;
          rk    <= rk + 5'd1;
          state <= S_MG;
        end
        S_Q_RD: state <= S_Q_CHK;
        S_Q_CHK: begin
          if (rdata.rank != 5'd0 && !rdata.free) res_value <= 16'(rdata.rank);
          else res_value <= 16'(fit_rank(pg, pool, TOP));
          state <= S_FIN;
        end
        S_CNT: begin
          res_value <= cnt_rk;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            status     <= res_status;
            alloc_page <= res_apage;
            value      <= res_value;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
